>>> hw/rtl/multi_encoding_char_decoder_macros.svh
// Assertion macros shared by the character decoder modules.
`ifndef MULTI_ENCODING_CHAR_DECODER_MACROS_SVH
`define MULTI_ENCODING_CHAR_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MECD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MECD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mecd_pkg.sv
// Types and constants for the multi-encoding character decoder.
package mecd_pkg;

  // Decode mode register codes
  typedef enum logic [1:0] {
    MODE_UTF8    = 2'd0,
    MODE_UTF16BE = 2'd1,
    MODE_CP1252  = 2'd2,
    MODE_SJIS    = 2'd3
  } mode_t;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned COUNT_W = 2;

  // Byte counts of a character
  localparam logic [COUNT_W-1:0] CNT_ONE   = 2'd1;
  localparam logic [COUNT_W-1:0] CNT_TWO   = 2'd2;
  localparam logic [COUNT_W-1:0] CNT_THREE = 2'd3;

  // One decoded result from the core
  typedef struct packed {
    logic               emit;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] bytes;
  } dec_result_t;

endpackage

>>> hw/rtl/mecd_if.sv
// Valid/ready channel interfaces for the character decoder.
interface mecd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mecd_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic [1:0]  char_bytes;
  modport source (output valid, output char_code, output char_bytes, input ready);
  modport sink   (input valid, input char_code, input char_bytes, output ready);
endinterface

interface mecd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] decode_mode;
  modport source (output valid, output decode_mode, input ready);
  modport sink   (input valid, input decode_mode, output ready);
endinterface

>>> hw/rtl/mecd_core.sv
// Decode core: mode register, partial-character state and per-byte decode.
`include "multi_encoding_char_decoder_macros.svh"

module mecd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [7:0]                in_byte,
  input  logic                      cfg_fire,
  input  logic [1:0]                cfg_mode,
  output mecd_pkg::dec_result_t     result
);

  mecd_pkg::mode_t                     mode_r;
  logic [mecd_pkg::CODE_W-1:0]         pend_r, pend_nxt;
  logic [mecd_pkg::COUNT_W-1:0]        held_r, held_nxt;
  logic [mecd_pkg::COUNT_W-1:0]        needed_r, needed_nxt;
  logic [mecd_pkg::CODE_W-1:0]         joined;
  logic [mecd_pkg::COUNT_W-1:0]        held_inc;
  logic                                sjis_lead;

  // Join the next byte onto the partial code by the current mode
  assign joined   = (mode_r == mecd_pkg::MODE_UTF8) ? {pend_r[9:0], in_byte[5:0]}
                                                    : {pend_r[7:0], in_byte};
  assign held_inc = held_r + 2'd1;
  assign sjis_lead = (in_byte >= 8'h81 && in_byte < 8'hA0) || (in_byte >= 8'hE0);

  // Decode one byte
  always_comb begin
    result     = '0;
    pend_nxt   = pend_r;
    held_nxt   = held_r;
    needed_nxt = needed_r;
    if (held_r == '0) begin
      unique case (mode_r)
        mecd_pkg::MODE_UTF8: begin
          if (!in_byte[7]) begin
            result = '{emit: 1'b1, code: {8'h00, in_byte}, bytes: mecd_pkg::CNT_ONE};
          end else begin
            pend_nxt   = {11'd0, in_byte[4:0]};
            held_nxt   = mecd_pkg::CNT_ONE;
            needed_nxt = (in_byte[7:5] == 3'b110) ? mecd_pkg::CNT_TWO
                                                  : mecd_pkg::CNT_THREE;
          end
        end
        mecd_pkg::MODE_UTF16BE: begin
          pend_nxt   = {8'h00, in_byte};
          held_nxt   = mecd_pkg::CNT_ONE;
          needed_nxt = mecd_pkg::CNT_TWO;
        end
        mecd_pkg::MODE_CP1252: begin
          result = '{emit: 1'b1, code: {8'h00, in_byte}, bytes: mecd_pkg::CNT_ONE};
        end
        mecd_pkg::MODE_SJIS: begin
          if (sjis_lead) begin
            pend_nxt   = {8'h00, in_byte};
            held_nxt   = mecd_pkg::CNT_ONE;
            needed_nxt = mecd_pkg::CNT_TWO;
          end else begin
            result = '{emit: 1'b1, code: {8'h00, in_byte}, bytes: mecd_pkg::CNT_ONE};
          end
        end
        default: begin
          result = '0;
        end
      endcase
    end else if (held_inc >= needed_r) begin
      result     = '{emit: 1'b1, code: joined, bytes: needed_r};
      pend_nxt   = '0;
      held_nxt   = '0;
      needed_nxt = '0;
    end else begin
      pend_nxt = joined;
      held_nxt = held_inc;
    end
    result.emit = result.emit & in_fire;
  end

  // Advance state on each byte transfer, load mode on each config transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mecd_pkg::MODE_UTF8;
      pend_r   <= '0;
      held_r   <= '0;
      needed_r <= '0;
    end else begin
      if (cfg_fire) begin
        mode_r <= mecd_pkg::mode_t'(cfg_mode);
      end
      if (in_fire) begin
        pend_r   <= pend_nxt;
        held_r   <= held_nxt;
        needed_r <= needed_nxt;
      end
    end
  end

  `MECD_ASSERT_NOW(a_held_le_needed, 1'b1, held_r <= needed_r, "held count exceeds needed count")
  `MECD_ASSERT_NOW(a_idle_clear, held_r == '0, needed_r == '0 && pend_r == '0, "idle state not clear")
  `MECD_ASSERT_NOW(a_needed_legal, 1'b1, needed_r == '0 || needed_r == mecd_pkg::CNT_TWO || needed_r == mecd_pkg::CNT_THREE, "illegal needed count")

endmodule

>>> hw/rtl/multi_encoding_char_decoder.sv
// Multi-encoding character decoder top level: decode core and output skid stage.
//
// Usage:
//   in_ch  : one text byte per transfer (valid/ready, payload in_byte).
//   out_ch : one decoded character per transfer (char_code, char_bytes).
//   cfg_ch : write of decode_mode (0 UTF-8, 1 UTF-16BE, 2 CP1252, 3 Shift-JIS);
//            always ready, write only while the block is idle.
// Throughput: one byte per cycle while in_ch.ready is high, set by the
// combinational decode between partial-character and output registers.
// Output: the result for the byte that completes a character is registered
// in the output register, or in the skid register while out_ch is stalled;
// bytes that do not complete a character give no result.
// Stall: the output register is backed by one skid register, so one
// extra result is absorbed while out_ch is stalled; in_ch.ready then drops
// until the skid register drains.
// Reset (rst_n low, synchronous): mode returns to UTF-8, partial-character
// state and the valid flags of both output registers are cleared. Partial
// state is otherwise never dropped, including across mode changes.
`include "multi_encoding_char_decoder_macros.svh"

module multi_encoding_char_decoder (
  input  logic         clk,
  input  logic         rst_n,
  mecd_byte_if.sink    in_ch,
  mecd_char_if.source  out_ch,
  mecd_cfg_if.sink     cfg_ch
);

  mecd_pkg::dec_result_t  dec;
  logic                   in_fire;
  logic                   out_fire;
  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [15:0]            out_code_r, skid_code_r;
  logic [1:0]             out_bytes_r, skid_bytes_r;

  // Accept bytes while the skid register is free
  assign in_ch.ready  = !skid_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_valid_r && out_ch.ready;

  mecd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_ch.in_byte),
    .cfg_fire (cfg_ch.valid),
    .cfg_mode (cfg_ch.decode_mode),
    .result   (dec)
  );

  // Output/skid control
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (dec.emit) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Hold or load payload registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_code_r  <= skid_code_r;
        out_bytes_r <= skid_bytes_r;
      end
    end else if (dec.emit) begin
      if (out_valid_r && !out_fire) begin
        skid_code_r  <= dec.code;
        skid_bytes_r <= dec.bytes;
      end else begin
        out_code_r  <= dec.code;
        out_bytes_r <= dec.bytes;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_code  = out_code_r;
  assign out_ch.char_bytes = out_bytes_r;

  `MECD_ASSERT_NOW(a_skid_implies_out, skid_valid_r, out_valid_r, "skid full while output empty")
  `MECD_ASSERT_NOW(a_no_emit_when_full, skid_valid_r, !dec.emit, "result produced with skid full")
  `MECD_ASSERT_NEXT(a_stall_to_skid, dec.emit && out_valid_r && !out_ch.ready, skid_valid_r, "stalled result not held in skid")

endmodule
